// ===== design/mkec_pkg.sv =====
// ----------------------------------------------------------------------------
// mkec_pkg
// Shared types, codes and multi-tap letter tables for the keypad entry
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mkec_pkg;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_BACK   = 3'd1,
        CMD_NEXT   = 3'd2,
        CMD_PREV   = 3'd3,
        CMD_COMMIT = 3'd4,
        CMD_ACTION = 3'd5,
        CMD_CLEAR  = 3'd6,
        CMD_PRESS  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_GET   = 2'd1,
        MODE_MERGE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        LED_L1_ON   = 3'd0,
        LED_L5_ON   = 3'd1,
        LED_OFF     = 3'd2,
        LED_L34_TGL = 3'd3,
        LED_L78_TGL = 3'd4
    } t_led;

    typedef enum logic [2:0] {
        REQ_NONE   = 3'd0,
        REQ_COMMIT = 3'd1,
        REQ_LOOKUP = 3'd2,
        REQ_MERGE  = 3'd3,
        REQ_ERROR  = 3'd4,
        REQ_TERM   = 3'd5
    } t_req;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] sw_digit;
        logic       merge_allowed;
    } t_evt;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  led_code;
        logic [15:0] key_digits;
        logic        val_write_valid;
        logic [3:0]  val_write_pos;
        logic [6:0]  val_write_char;
        logic        entry_is_key;
        logic        english_on;
        logic        entries_cleared;
        logic [2:0]  request;
    } t_res;

    // control from the top level into the value ring
    typedef struct packed {
        logic       clear;
        logic       push;
        logic       english;
        logic [3:0] digit;
    } t_val_ctrl;

    // value character write reported back by the value ring
    typedef struct packed {
        logic       valid;
        logic [3:0] pos;
        logic [6:0] ch;
    } t_val_wr;

    typedef struct packed {
        logic       hit;
        logic [6:0] ch;
    } t_mt;

    localparam logic [6:0] CHAR_ZERO = 7'h30;

    // letter sets for keys 2..9, padded with zero
    localparam logic [6:0] LETTERS [8][4] = '{
        '{7'h41, 7'h42, 7'h43, 7'h00},
        '{7'h44, 7'h45, 7'h46, 7'h00},
        '{7'h47, 7'h48, 7'h49, 7'h00},
        '{7'h4A, 7'h4B, 7'h4C, 7'h00},
        '{7'h4D, 7'h4E, 7'h4F, 7'h00},
        '{7'h50, 7'h51, 7'h52, 7'h53},
        '{7'h54, 7'h55, 7'h56, 7'h00},
        '{7'h57, 7'h58, 7'h59, 7'h5A}
    };

    localparam logic [2:0] LET_LEN [8] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd4
    };

    function automatic logic [2:0] set_index(input logic [3:0] d);
        logic [3:0] t;
        t = d - 4'd2;
        return t[2:0];
    endfunction

    function automatic logic [6:0] first_letter(input logic [3:0] d);
        return LETTERS[set_index(d)][0];
    endfunction

    // find prev in the key's set and return the letter after it, wrapping
    function automatic t_mt mt_next(input logic [3:0] d, input logic [6:0] prev);
        t_mt        r;
        logic [2:0] idx;
        idx  = set_index(d);
        r.hit = 1'b0;
        r.ch  = LETTERS[idx][0];
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < LET_LEN[idx] && LETTERS[idx][i] == prev) begin
                r.hit = 1'b1;
                if (3'(i + 1) < LET_LEN[idx]) begin
                    r.ch = LETTERS[idx][(i + 1) % 4];
                end else begin
                    r.ch = LETTERS[idx][0];
                end
            end
        end
        return r;
    endfunction

    function automatic t_led led_on_mode(input t_mode m);
        t_led l;
        unique case (m)
            MODE_PUT:   l = LED_L1_ON;
            MODE_GET:   l = LED_L5_ON;
            MODE_MERGE: l = LED_OFF;
            default:    l = LED_OFF;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// ===== design/mkec_if.sv =====
// ----------------------------------------------------------------------------
// mkec_if
// Valid/ready channels for keypad events and controller results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkec_evt_if;
    logic             valid;
    logic             ready;
    mkec_pkg::t_evt   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mkec_res_if;
    logic             valid;
    logic             ready;
    mkec_pkg::t_res   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/mkec_val_ring.sv =====
// ----------------------------------------------------------------------------
// mkec_val_ring
// Value ring write pointer with multi-tap letter stepping. Only the first
// character and the most recently written one are ever read back, so those
// two are kept instead of the whole ring.
// ----------------------------------------------------------------------------
`default_nettype none

module mkec_val_ring #(
    parameter int VAL_LEN = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mkec_pkg::t_val_ctrl  i_ctrl,
    output mkec_pkg::t_val_wr         o_wr,
    output logic                      o_val0_nz
);
    import mkec_pkg::*;

    localparam int VP_W = $clog2(VAL_LEN);
    localparam logic [VP_W-1:0] LAST_POS = VP_W'(VAL_LEN - 1);

    logic [VP_W-1:0] r_pos;
    logic [6:0]      r_val0;
    logic [6:0]      r_last;

    logic [VP_W-1:0] prev_pos;
    logic [VP_W-1:0] wr_pos;
    logic [VP_W-1:0] n_pos;
    logic [31:0]     pos_ext;
    logic [6:0]      ch;
    logic            wr_ok;
    t_mt             mt;

    always_comb begin
        prev_pos = (r_pos == '0) ? LAST_POS : r_pos - 1'b1;
        mt       = mt_next(i_ctrl.digit, r_last);
        wr_ok    = i_ctrl.push && i_ctrl.digit >= 4'd2 && i_ctrl.digit <= 4'd9;
        wr_pos   = r_pos;
        ch       = CHAR_ZERO + {3'b000, i_ctrl.digit};
        if (i_ctrl.english) begin
            ch = first_letter(i_ctrl.digit);
            // a repeated press rewrites the previous character
            if (r_val0 != '0 && mt.hit) begin
                ch     = mt.ch;
                wr_pos = prev_pos;
            end
        end
        n_pos   = (wr_pos == LAST_POS) ? '0 : wr_pos + 1'b1;
        pos_ext = 32'(wr_pos);

        o_wr.valid = wr_ok;
        o_wr.pos   = wr_ok ? pos_ext[3:0] : 4'd0;
        o_wr.ch    = wr_ok ? ch : 7'd0;
        o_val0_nz  = (r_val0 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_pos  <= '0;
            r_val0 <= '0;
            r_last <= '0;
        end else if (wr_ok) begin
            r_pos  <= n_pos;
            r_last <= ch;
            if (wr_pos == '0) begin
                r_val0 <= ch;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/multitap_keypad_entry_controller_top.sv =====
// An accepted event's result appears in the output register in the cycle after it is accepted.
// Throughput: one event per cycle while results are taken; the output register frees in the cycle it transfers.
// Each event's state update is a single compare-and-write pass before that register.
// Reset (synchronous, active low): put mode, LED1 on, key entry, English off,
// key and value rings cleared, no result pending.
// ----------------------------------------------------------------------------
// multitap_keypad_entry_controller_top
// Keypad event controller: mode, LED action, key digit ring and multi-tap
// value entry, with commit, lookup, merge, error and terminate requests.
// ----------------------------------------------------------------------------
`default_nettype none

module multitap_keypad_entry_controller_top #(
    parameter int KEY_DIGITS = 4,
    parameter int VAL_LEN    = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mkec_evt_if.sink        i_evt,
    mkec_res_if.source      o_res
);
    import mkec_pkg::*;

    localparam int KP_W = (KEY_DIGITS > 1) ? $clog2(KEY_DIGITS) : 1;
    localparam logic [KP_W-1:0] KEY_LAST = KP_W'(KEY_DIGITS - 1);

    t_mode           r_mode, n_mode;
    t_led            r_led, n_led;
    logic            r_key_entry, n_key_entry;
    logic            r_english, n_english;
    logic [3:0]      r_key [KEY_DIGITS];
    logic [3:0]      n_key [KEY_DIGITS];
    logic [KP_W-1:0] r_key_pos, n_key_pos;
    t_res            r_res;
    logic            r_res_valid;

    logic            accept;
    logic            settle;
    logic            key_clr;
    logic            key_push;
    logic            val_clr;
    logic            val_push;
    logic            cleared;
    t_req            req;
    t_cmd            cmd;
    logic [3:0]      dig;
    logic [15:0]     packed_keys;
    t_val_ctrl       val_ctrl;
    t_val_wr         val_wr;
    logic            val0_nz;

    assign i_evt.ready = !r_res_valid || o_res.ready;
    assign accept      = i_evt.valid && i_evt.ready;
    assign cmd         = t_cmd'(i_evt.data.cmd);
    assign dig         = i_evt.data.sw_digit;

    always_comb begin
        n_mode      = r_mode;
        n_led       = r_led;
        n_key_entry = r_key_entry;
        n_english   = r_english;
        settle      = 1'b0;
        key_clr     = 1'b0;
        key_push    = 1'b0;
        val_clr     = 1'b0;
        val_push    = 1'b0;
        cleared     = 1'b0;
        req         = REQ_NONE;

        unique case (cmd)
            CMD_NONE: ;
            CMD_BACK: req = REQ_TERM;
            CMD_NEXT: begin
                unique case (r_mode)
                    MODE_PUT: n_mode = MODE_GET;
                    MODE_GET: n_mode = MODE_MERGE;
                    default:  n_mode = MODE_PUT;
                endcase
                settle = 1'b1;
            end
            CMD_PREV: begin
                unique case (r_mode)
                    MODE_PUT: n_mode = MODE_MERGE;
                    MODE_GET: n_mode = MODE_PUT;
                    default:  n_mode = MODE_GET;
                endcase
                settle = 1'b1;
            end
            CMD_COMMIT: begin
                if (r_mode == MODE_PUT) begin
                    req    = (r_key[0] != 4'd0 && val0_nz) ? REQ_COMMIT : REQ_ERROR;
                    settle = 1'b1;
                end
            end
            CMD_ACTION: begin
                unique case (r_mode)
                    MODE_PUT: begin
                        // swap the entry LED along with the entry target
                        if (r_led == LED_L34_TGL) begin
                            n_led = LED_L78_TGL;
                        end else if (r_led == LED_L78_TGL) begin
                            n_led = LED_L34_TGL;
                        end
                        n_key_entry = !r_key_entry;
                    end
                    MODE_GET: begin
                        req    = (r_key[0] != 4'd0) ? REQ_LOOKUP : REQ_ERROR;
                        settle = 1'b1;
                    end
                    default: begin
                        req    = i_evt.data.merge_allowed ? REQ_MERGE : REQ_ERROR;
                        settle = 1'b1;
                    end
                endcase
            end
            CMD_CLEAR: begin
                if (r_mode == MODE_PUT) begin
                    key_clr = r_key_entry;
                    val_clr = !r_key_entry;
                    cleared = 1'b1;
                end
            end
            CMD_PRESS: begin
                if (dig == 4'd1 && r_mode == MODE_PUT && !r_key_entry) begin
                    n_english = !r_english;
                end else if (dig >= 4'd1 && dig <= 4'd9) begin
                    if (r_mode == MODE_PUT) begin
                        n_led    = r_key_entry ? LED_L34_TGL : LED_L78_TGL;
                        key_push = r_key_entry;
                        val_push = !r_key_entry;
                    end else if (r_mode == MODE_GET) begin
                        n_led    = LED_L34_TGL;
                        key_push = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (settle) begin
            n_led       = led_on_mode(n_mode);
            n_english   = 1'b0;
            n_key_entry = 1'b1;
            key_clr     = 1'b1;
            val_clr     = 1'b1;
            cleared     = 1'b1;
        end

        n_key     = r_key;
        n_key_pos = r_key_pos;
        if (key_clr) begin
            for (int i = 0; i < KEY_DIGITS; i++) begin
                n_key[i] = 4'd0;
            end
            n_key_pos = '0;
        end else if (key_push) begin
            n_key[r_key_pos] = dig;
            n_key_pos        = (r_key_pos == KEY_LAST) ? '0 : r_key_pos + 1'b1;
        end

        val_ctrl.clear   = accept && val_clr;
        val_ctrl.push    = accept && val_push;
        val_ctrl.english = r_english;
        val_ctrl.digit   = dig;
    end

    // only the first four digits are visible on the result
    for (genvar g = 0; g < 4; g++) begin : g_pack
        if (g < KEY_DIGITS) begin : g_dig
            assign packed_keys[4*g +: 4] = n_key[g];
        end else begin : g_pad
            assign packed_keys[4*g +: 4] = 4'd0;
        end
    end

    mkec_val_ring #(
        .VAL_LEN (VAL_LEN)
    ) u_val_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (val_ctrl),
        .o_wr      (val_wr),
        .o_val0_nz (val0_nz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_PUT;
            r_led       <= LED_L1_ON;
            r_key_entry <= 1'b1;
            r_english   <= 1'b0;
            r_key_pos   <= '0;
            for (int i = 0; i < KEY_DIGITS; i++) begin
                r_key[i] <= 4'd0;
            end
        end else if (accept) begin
            r_mode      <= n_mode;
            r_led       <= n_led;
            r_key_entry <= n_key_entry;
            r_english   <= n_english;
            r_key_pos   <= n_key_pos;
            r_key       <= n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res.mode            <= n_mode;
            r_res.led_code        <= n_led;
            r_res.key_digits      <= packed_keys;
            r_res.val_write_valid <= val_wr.valid;
            r_res.val_write_pos   <= val_wr.pos;
            r_res.val_write_char  <= val_wr.ch;
            r_res.entry_is_key    <= n_key_entry;
            r_res.english_on      <= n_english;
            r_res.entries_cleared <= cleared;
            r_res.request         <= req;
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.request == REQ_COMMIT
        |-> r_res.mode == MODE_PUT && r_res.entries_cleared && r_res.entry_is_key)
        else $error("commit result without put-mode reset");

    a_term_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.request == REQ_TERM
        |-> !r_res.entries_cleared && !r_res.val_write_valid)
        else $error("terminate request changed entries");

    a_digit_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.val_write_valid && !r_res.english_on
        |-> r_res.val_write_char >= 7'h32 && r_res.val_write_char <= 7'h39)
        else $error("numeric value character out of range");

    a_idle_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && cmd == CMD_NONE
        |=> $stable(r_mode) && $stable(r_key_pos) && $stable(r_english))
        else $error("empty event changed state");

endmodule

`default_nettype wire
